[src/tscd_pkg.sv]
// Shared types and codes of the species density deposit block.
`timescale 1ns / 1ps
package tscd_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AMT_A,
        ST_AMT_B,
        ST_AX_MUL,
        ST_AX_FRAC,
        ST_AX_SQA,
        ST_AX_SQH,
        ST_AX_SQR,
        ST_NODES,
        ST_DRAIN,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_AMT_A,
        CMD_AMT_B,
        CMD_AX_MUL,
        CMD_AX_FRAC,
        CMD_SQA,
        CMD_SQH,
        CMD_SQR,
        CMD_NODE,
        CMD_CLEAR,
        CMD_READ,
        CMD_READ_DATA,
        CMD_LOAD_OUT
    } cmd_op_t;

    typedef enum logic [1:0] {
        REQ_DEPOSIT = 2'd0,
        REQ_READ    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_DROPPED   = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] REG_INV_X      = 3'd3;
    localparam logic [2:0] REG_INV_Y      = 3'd4;
    localparam logic [2:0] REG_INV_Z      = 3'd5;
    localparam logic [2:0] REG_SCALE      = 3'd6;
    localparam logic [2:0] REG_COLLAPSE   = 3'd7;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic node_last;
        logic pipe_empty;
        logic outside;
        logic out_free;
    } stat_t;

endpackage

[src/tscd_ctrl.sv]
// Sequencing state machine of the species density deposit block.
`timescale 1ns / 1ps
module tscd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_type,
    output logic           req_stall,
    input  tscd_pkg::stat_t stat,
    output tscd_pkg::cmd_t  cmd
);
    import tscd_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       report_reg, report_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            axis_reg   <= 2'd0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        report_next = report_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next  = report_reg ? ST_DONE : ST_IDLE;
                    report_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_type)
                        REQ_DEPOSIT:
                        begin
                            state_next = ST_AMT_A;
                            axis_next  = 2'd0;
                        end
                        REQ_READ:  state_next = ST_READ;
                        REQ_CLEAR:
                        begin
                            state_next  = ST_CLEAR;
                            report_next = 1'b1;
                        end
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_AMT_A:     state_next = ST_AMT_B;
            ST_AMT_B:     state_next = ST_AX_MUL;
            ST_AX_MUL:    state_next = ST_AX_FRAC;
            ST_AX_FRAC:   state_next = stat.outside ? ST_DONE : ST_AX_SQA;
            ST_AX_SQA:    state_next = ST_AX_SQH;
            ST_AX_SQH:    state_next = ST_AX_SQR;
            ST_AX_SQR:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_NODES;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AX_MUL;
                end
            end
            ST_NODES:     if (stat.node_last) state_next = ST_DRAIN;
            ST_DRAIN:     if (stat.pipe_empty) state_next = ST_DONE;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_DONE:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.axis  = axis_reg;
        cmd.op    = CMD_NONE;
        req_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:     cmd.op = CMD_CLEAR;
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid) cmd.op = CMD_ACCEPT;
            end
            ST_AMT_A:     cmd.op = CMD_AMT_A;
            ST_AMT_B:     cmd.op = CMD_AMT_B;
            ST_AX_MUL:    cmd.op = CMD_AX_MUL;
            ST_AX_FRAC:   cmd.op = CMD_AX_FRAC;
            ST_AX_SQA:    cmd.op = CMD_SQA;
            ST_AX_SQH:    cmd.op = CMD_SQH;
            ST_AX_SQR:    cmd.op = CMD_SQR;
            ST_NODES:     cmd.op = CMD_NODE;
            ST_READ:      cmd.op = CMD_READ;
            ST_READ_DATA: cmd.op = CMD_READ_DATA;
            ST_DONE:      if (stat.out_free) cmd.op = CMD_LOAD_OUT;
            default:      cmd.op = CMD_NONE;
        endcase
    end

endmodule

[src/tscd_datapath.sv]
// Arithmetic, grid memory, configuration registers and output register of the deposit block.
`timescale 1ns / 1ps
module tscd_datapath #(
    parameter int CELLS_X   = 13,
    parameter int CELLS_Y   = 13,
    parameter int CELLS_Z   = 13,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] charge,
    input  logic [15:0]        weight,
    input  logic [1:0]         read_species,
    input  logic [11:0]        read_cell,
    input  tscd_pkg::cmd_t     cmd,
    output tscd_pkg::stat_t    stat,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output logic signed [31:0] read_value,
    output logic [1:0]         status
);
    import tscd_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int NXN   = CELLS_X + 2;
    localparam int NYN   = CELLS_Y + 2;
    localparam int NZN   = CELLS_Z + 2;
    localparam int NODES = NXN * NYN * NZN;
    localparam int DEPTH = 3 * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMAX  = (NXN > NYN) ? ((NXN > NZN) ? NXN : NZN) : ((NYN > NZN) ? NYN : NZN);
    localparam int JW    = $clog2(CMAX);
    localparam int SH    = 32 - F;
    localparam int UW    = 34 + F;
    localparam int TW    = UW + 1;
    localparam int WW    = F + 1;
    localparam int SW    = F + 65;
    localparam int CW    = 34;
    localparam logic [WW-1:0] ONE   = WW'(1) << F;
    localparam logic [WW-1:0] HALF  = WW'(1) << (F - 1);
    localparam logic [WW-1:0] W34   = WW'(3 * (1 << F) / 4);
    localparam logic [CW-1:0] CLAMP = CW'(1) << 33;

    // Configuration registers.
    logic signed [31:0] org_reg [3];
    logic [31:0]        inv_reg [3];
    logic [31:0]        scale_reg;
    logic [2:0]         col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            inv_reg[0] <= 32'd65536;
            inv_reg[1] <= 32'd65536;
            inv_reg[2] <= 32'd65536;
            scale_reg  <= 32'd65536;
            col_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_INV_X:    inv_reg[0] <= cfg_data;
                REG_INV_Y:    inv_reg[1] <= cfg_data;
                REG_INV_Z:    inv_reg[2] <= cfg_data;
                REG_SCALE:    scale_reg  <= cfg_data;
                REG_COLLAPSE: col_reg    <= cfg_data[2:0];
                default:      col_reg    <= col_reg;
            endcase
        end
    end

    // Latched request fields.
    logic signed [31:0] pos_reg [3];
    logic [15:0]        mq_reg;
    logic [15:0]        wt_reg;
    logic [1:0]         sp_reg;
    logic               neg_reg;
    logic [1:0]         rd_sp_reg;
    logic [11:0]        rd_cell_reg;
    logic               rd_ok_reg;

    // Setup values.
    logic [31:0]        amt1_reg;
    logic [63:0]        amount_reg;
    logic [63:0]        prod_reg;
    logic               dneg_reg;
    logic [F-1:0]       r_reg;
    logic [JW-1:0]      j_reg [3];
    logic [WW-1:0]      wx_reg [3];
    logic [WW-1:0]      wy_reg [3];
    logic [WW-1:0]      wz_reg [3];

    // Result being built and output register.
    logic signed [31:0] res_value_reg;
    logic [1:0]         res_status_reg;
    logic               rsp_valid_reg;
    logic signed [31:0] rsp_value_reg;
    logic [1:0]         rsp_status_reg;

    // Shared setup multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [63:0]        fl_q;
    logic [64:0]        cl_q;
    logic [UW-1:0]      fl_u, cl_u;
    logic signed [UW-1:0] u_val;
    logic signed [TW-1:0] t_val;
    logic signed [TW-1:0] jw_val;
    logic               out_axis;
    logic [F-1:0]       hm;
    logic [WW-1:0]      a_val;
    logic               col_sel;

    always_comb
    begin
        col_sel = col_reg[cmd.axis];
        diff    = 33'(pos_reg[cmd.axis]) - 33'(org_reg[cmd.axis]);
        mag     = diff[32] ? 32'(-diff) : diff[31:0];
        fl_q    = prod_reg >> SH;
        cl_q    = (65'(prod_reg) + 65'((64'(1) << SH) - 64'(1))) >> SH;
        fl_u    = fl_q[UW-1:0];
        cl_u    = cl_q[UW-1:0];
        u_val   = dneg_reg ? -$signed(cl_u) : $signed(fl_u);
        t_val   = TW'(u_val) + $signed(TW'(HALF));
        jw_val  = t_val >>> F;
        case (cmd.axis)
            2'd0:    out_axis = t_val[TW-1] || (jw_val >= $signed(TW'(CELLS_X)));
            2'd1:    out_axis = t_val[TW-1] || (jw_val >= $signed(TW'(CELLS_Y)));
            default: out_axis = t_val[TW-1] || (jw_val >= $signed(TW'(CELLS_Z)));
        endcase
        hm    = (WW'(r_reg) <= HALF) ? F'(HALF - WW'(r_reg)) : F'(WW'(r_reg) - HALF);
        a_val = ONE - WW'(r_reg);
        case (cmd.op)
            CMD_AMT_A:
            begin
                mul_a = 32'(mq_reg);
                mul_b = 32'(wt_reg);
            end
            CMD_AMT_B:
            begin
                mul_a = amt1_reg;
                mul_b = scale_reg;
            end
            CMD_AX_MUL:
            begin
                mul_a = mag;
                mul_b = inv_reg[cmd.axis];
            end
            CMD_SQA:
            begin
                mul_a = 32'(a_val);
                mul_b = 32'(a_val);
            end
            CMD_SQH:
            begin
                mul_a = 32'(hm);
                mul_b = 32'(hm);
            end
            default:
            begin
                mul_a = 32'(r_reg);
                mul_b = 32'(r_reg);
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Node sequencing and update pipeline.
    logic [1:0]          dx_reg, dy_reg, dz_reg;
    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2*WW-1:0]     wxy1_reg;
    logic [WW-1:0]       wz1_reg;
    logic [WW-1:0]       nw2_reg;
    logic [F+32:0]       lo3_reg;
    logic [F+32:0]       hi3_reg;
    logic [CW-1:0]       c4_reg;
    logic [AW-1:0]       addr1_reg, addr2_reg, addr3_reg, addr4_reg;
    logic [AW-1:0]       clr_reg;
    logic [AW-1:0]       node_addr, rd_addr, mem_raddr, mem_waddr;
    logic [AW-1:0]       ax_i, ay_i, az_i;
    logic [2*WW+1:0]     nw_full;
    logic [WW-1:0]       wx_s, wy_s, wz_s;
    logic [SW-1:0]       sum_full;
    logic [SW-1:0]       c_full;
    logic [CW-1:0]       c_val;
    logic signed [35:0]  v_sum;
    logic signed [31:0]  v_sat;
    logic                v_clip;
    logic                mem_we;
    logic [31:0]         mem_wdata;
    logic [31:0]         rdata_reg;
    logic [31:0]         mem [DEPTH];
    logic                node_last;

    always_comb
    begin
        wx_s      = wx_reg[dx_reg];
        wy_s      = wy_reg[dy_reg];
        wz_s      = wz_reg[dz_reg];
        ax_i      = AW'(j_reg[0]) + AW'(dx_reg);
        ay_i      = AW'(j_reg[1]) + AW'(dy_reg);
        az_i      = AW'(j_reg[2]) + AW'(dz_reg);
        node_addr = AW'(sp_reg) * AW'(NODES) + (az_i * AW'(NYN) + ay_i) * AW'(NXN) + ax_i;
        rd_addr   = AW'(rd_sp_reg) * AW'(NODES) + AW'(rd_cell_reg);
        node_last = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);
        nw_full   = (2*WW+2)'(wxy1_reg >> F) * (2*WW+2)'(wz1_reg);
        sum_full  = {hi3_reg, 32'd0} + SW'(lo3_reg);
        c_full    = sum_full >> (16 + F);
        c_val     = (c_full > SW'(CLAMP)) ? CLAMP : c_full[CW-1:0];
        v_sum     = neg_reg ? (36'($signed(rdata_reg)) - $signed(36'(c4_reg)))
                            : (36'($signed(rdata_reg)) + $signed(36'(c4_reg)));
        v_clip    = 1'b1;
        if (v_sum > 36'sd2147483647)
        begin
            v_sat = 32'sh7fffffff;
        end
        else if (v_sum < -36'sd2147483648)
        begin
            v_sat = 32'sh80000000;
        end
        else
        begin
            v_sat  = v_sum[31:0];
            v_clip = 1'b0;
        end
        mem_raddr = (cmd.op == CMD_READ) ? rd_addr : addr3_reg;
        if (cmd.op == CMD_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = v4_reg;
            mem_waddr = addr4_reg;
            mem_wdata = v_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        wxy1_reg  <= (2*WW)'(wx_s) * (2*WW)'(wy_s);
        wz1_reg   <= wz_s;
        addr1_reg <= node_addr;
        nw2_reg   <= nw_full[WW-1+F:F];
        addr2_reg <= addr1_reg;
        lo3_reg   <= (F+33)'(amount_reg[31:0]) * (F+33)'(nw2_reg);
        hi3_reg   <= (F+33)'(amount_reg[63:32]) * (F+33)'(nw2_reg);
        addr3_reg <= addr2_reg;
        c4_reg    <= c_val;
        addr4_reg <= addr3_reg;
    end

    // Datapath payload registers updated by command.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_ACCEPT:
            begin
                pos_reg[0]  <= pos_x;
                pos_reg[1]  <= pos_y;
                pos_reg[2]  <= pos_z;
                wt_reg      <= weight;
                neg_reg     <= charge[15];
                if (charge[15])
                begin
                    mq_reg <= 16'(-charge);
                    sp_reg <= 2'd0;
                end
                else if (charge != 16'sd0)
                begin
                    mq_reg <= charge;
                    sp_reg <= 2'd1;
                end
                else
                begin
                    mq_reg <= 16'd256;
                    sp_reg <= 2'd2;
                end
                rd_sp_reg   <= read_species;
                rd_cell_reg <= read_cell;
                rd_ok_reg   <= (read_species != 2'd3) && (32'(read_cell) < 32'(NODES));
            end
            CMD_AMT_A:  amt1_reg   <= mul_p[31:0];
            CMD_AMT_B:  amount_reg <= mul_p;
            CMD_AX_MUL:
            begin
                prod_reg <= mul_p;
                dneg_reg <= diff[32];
            end
            CMD_AX_FRAC:
            begin
                r_reg           <= col_sel ? F'(0) : t_val[F-1:0];
                j_reg[cmd.axis] <= col_sel ? JW'(0) : jw_val[JW-1:0];
            end
            CMD_SQA:
            begin
                case (cmd.axis)
                    2'd0:    wx_reg[0] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                    2'd1:    wy_reg[0] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                    default: wz_reg[0] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                endcase
            end
            CMD_SQH:
            begin
                case (cmd.axis)
                    2'd0:    wx_reg[1] <= col_sel ? ONE : W34 - WW'(mul_p >> F);
                    2'd1:    wy_reg[1] <= col_sel ? ONE : W34 - WW'(mul_p >> F);
                    default: wz_reg[1] <= col_sel ? ONE : W34 - WW'(mul_p >> F);
                endcase
            end
            CMD_SQR:
            begin
                case (cmd.axis)
                    2'd0:    wx_reg[2] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                    2'd1:    wy_reg[2] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                    default: wz_reg[2] <= col_sel ? WW'(0) : WW'(mul_p >> (F + 1));
                endcase
            end
            default:    amt1_reg <= amt1_reg;
        endcase
    end

    // Control registers: counters, pipeline valid bits, result and output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg         <= '0;
            dy_reg         <= '0;
            dz_reg         <= '0;
            clr_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_value_reg  <= '0;
            rsp_status_reg <= STATUS_OK;
        end
        else
        begin
            v1_reg <= (cmd.op == CMD_NODE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.op == CMD_NODE)
            begin
                if (dx_reg == 2'd2)
                begin
                    dx_reg <= 2'd0;
                    if (dy_reg == 2'd2)
                    begin
                        dy_reg <= 2'd0;
                        dz_reg <= (dz_reg == 2'd2) ? 2'd0 : dz_reg + 2'd1;
                    end
                    else
                    begin
                        dy_reg <= dy_reg + 2'd1;
                    end
                end
                else
                begin
                    dx_reg <= dx_reg + 2'd1;
                end
            end
            if (cmd.op == CMD_CLEAR)
            begin
                clr_reg <= (clr_reg == AW'(DEPTH - 1)) ? '0 : clr_reg + AW'(1);
            end
            if (cmd.op == CMD_ACCEPT)
            begin
                res_value_reg  <= '0;
                res_status_reg <= STATUS_OK;
            end
            else if (cmd.op == CMD_AX_FRAC && out_axis && !col_sel)
            begin
                res_status_reg <= STATUS_DROPPED;
            end
            else if (cmd.op == CMD_READ_DATA)
            begin
                res_value_reg <= rd_ok_reg ? rdata_reg : '0;
            end
            else if (v4_reg && v_clip)
            begin
                res_status_reg <= STATUS_SATURATED;
            end
            if (cmd.op == CMD_LOAD_OUT)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_value_reg  <= res_value_reg;
                rsp_status_reg <= res_status_reg;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.clear_last = (clr_reg == AW'(DEPTH - 1));
        stat.node_last  = node_last;
        stat.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
        stat.outside    = out_axis && !col_sel;
        stat.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = rsp_value_reg;
    assign status     = rsp_status_reg;

endmodule

[src/tsc_species_density_deposit_unit.sv]
// Top level of the species density deposit block.
//
// Requests arrive on the req channel (req_valid, req_stall) and each gives one
// result item on the rsp channel (rsp_valid, rsp_stall) carrying read_value and
// status. A deposit spreads one particle over the 27 nodes around it in the
// grid of its species, a read returns one stored node and a clear zeroes all
// three grids. Configuration registers are written on cfg_we with cfg_index
// and cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. One request is worked on at a time. A
// deposit is taken, its amount formed and each axis put through the multiply,
// fraction and weight-square steps on the shared setup multiplier; the 27
// stencil nodes then go into the read-modify-write pipeline of the grid
// memory, which drains before the result is handed over. A particle outside
// the grid ends early. A clear sweeps the memory one entry a cycle over all
// 3*(CELLS_X+2)*(CELLS_Y+2)*(CELLS_Z+2) entries (10125 at the default size).
// After reset the same sweep runs before the first request is taken.
// The result waits in an output register while the receiver stalls; the next
// request is taken meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps
module tsc_species_density_deposit_unit #(
    parameter int CELLS_X   = 13,
    parameter int CELLS_Y   = 13,
    parameter int CELLS_Z   = 13,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] charge,
    input  logic [15:0]        weight,
    input  logic [1:0]         read_species,
    input  logic [11:0]        read_cell,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]         status
);
    import tscd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tscd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tscd_datapath #(
        .CELLS_X   (CELLS_X),
        .CELLS_Y   (CELLS_Y),
        .CELLS_Z   (CELLS_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .charge       (charge),
        .weight       (weight),
        .read_species (read_species),
        .read_cell    (read_cell),
        .cmd          (cmd),
        .stat         (stat),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .read_value   (read_value),
        .status       (status)
    );

endmodule

[src/tscd_checker.sv]
// Port level assertions of the deposit block and their binding to the top level.
`timescale 1ns / 1ps
module tscd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] read_value,
    input logic [1:0]  status
);
    import tscd_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item taken while one is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_OK || status == STATUS_DROPPED ||
                       status == STATUS_SATURATED))
        else $error("undefined status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> read_value == 32'd0)
        else $error("deposit result carries a value");

endmodule

bind tsc_species_density_deposit_unit tscd_checker u_tscd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .status     (status)
);

[sim/tsc_species_density_deposit_unit_tb.sv]
// Self-checking testbench for the species density deposit unit with random traffic.
`timescale 1ns / 1ps
module tsc_species_density_deposit_unit_tb;
    import tscd_pkg::*;

    localparam int CX = 13;
    localparam int CY = 13;
    localparam int CZ = 13;
    localparam int NX = CX + 2;
    localparam int NY = CY + 2;
    localparam int NODES = NX * NY * (CZ + 2);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 80;

    typedef struct {
        req_t        kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] q;
        logic [15:0] w;
        logic [1:0]  sp;
        logic [11:0] node_idx;
    } request_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  st;
    } result_t;

    class density_tracker;
        int          grid[3][NODES];
        logic [31:0] regs[8];
        result_t     awaited[$];
        int          errors;
        int          last_idx;

        function new();
            foreach (grid[s, n]) grid[s][n] = 0;
            regs = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0};
            errors = 0;
            last_idx = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            regs[idx] = (idx == REG_COLLAPSE) ? {29'd0, data[2:0]} : data;
        endfunction

        function bit place_axis(logic [31:0] pos, logic [31:0] org, logic [31:0] inv,
                                int cells, bit col, output int node,
                                output longint unsigned wts[3]);
            longint d, u, t, j, h;
            longint unsigned mag, prod, a, b, hm;
            node = 0;
            wts = '{0, 65536, 0};
            if (col) return 1;
            d = longint'($signed(pos)) - longint'($signed(org));
            mag = (d < 0) ? -d : d;
            prod = mag * {32'd0, inv};
            if (d >= 0) u = prod >> 16;
            else u = -longint'((prod + 65535) >> 16);
            t = u + 32768;
            if (t < 0) return 0;
            j = t >>> 16;
            if (j >= cells) return 0;
            h = j * 65536 - u;
            a = 32768 + h;
            b = 32768 - h;
            hm = (h < 0) ? -h : h;
            wts[0] = (a * a) >> 17;
            wts[1] = 49152 - ((hm * hm) >> 16);
            wts[2] = (b * b) >> 17;
            node = int'(j);
            return 1;
        endfunction

        function logic [1:0] deposit(request_t r);
            int jx, jy, jz, sp, idx;
            longint unsigned wx[3], wy[3], wz[3], amount, nw, c;
            longint qv, v;
            bit ok, neg, sat;
            logic [127:0] wide;
            ok = place_axis(r.px, regs[REG_ORIGIN_X], regs[REG_INV_X], CX, regs[7][0], jx, wx);
            ok &= place_axis(r.py, regs[REG_ORIGIN_Y], regs[REG_INV_Y], CY, regs[7][1], jy, wy);
            ok &= place_axis(r.pz, regs[REG_ORIGIN_Z], regs[REG_INV_Z], CZ, regs[7][2], jz, wz);
            if (!ok) return STATUS_DROPPED;
            qv = longint'($signed(r.q));
            neg = 0;
            if (qv < 0) begin
                amount = longint'(-qv) * r.w * regs[REG_SCALE];
                sp = 0;
                neg = 1;
            end else if (qv > 0) begin
                amount = qv * r.w * regs[REG_SCALE];
                sp = 1;
            end else begin
                amount = (longint'(r.w) * regs[REG_SCALE]) << 8;
                sp = 2;
            end
            sat = 0;
            last_idx = (jz * NY + jy) * NX + jx;
            for (int dz = 0; dz < 3; dz++)
                for (int dy = 0; dy < 3; dy++)
                    for (int dx = 0; dx < 3; dx++)
                    begin
                        nw = (((wx[dx] * wy[dy]) >> 16) * wz[dz]) >> 16;
                        wide = {64'd0, amount} * {64'd0, nw};
                        c = wide[95:32];
                        if (c > (64'd1 << 33)) c = 64'd1 << 33;
                        idx = ((jz + dz) * NY + (jy + dy)) * NX + (jx + dx);
                        v = grid[sp][idx];
                        v = neg ? v - longint'(c) : v + longint'(c);
                        if (v > 64'sd2147483647) begin
                            v = 64'sd2147483647;
                            sat = 1;
                        end
                        if (v < -64'sd2147483648) begin
                            v = -64'sd2147483648;
                            sat = 1;
                        end
                        grid[sp][idx] = int'(v);
                    end
            return sat ? STATUS_SATURATED : STATUS_OK;
        endfunction

        function void note_request(request_t r);
            result_t e;
            e.value = 0;
            e.st = STATUS_OK;
            case (r.kind)
                REQ_DEPOSIT: e.st = deposit(r);
                REQ_READ:
                    if (r.sp < 3 && r.node_idx < NODES) e.value = grid[r.sp][r.node_idx];
                REQ_CLEAR: foreach (grid[s, n]) grid[s][n] = 0;
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] st);
            result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result value %h status %0d", $time, value, st);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (value !== e.value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (st !== e.st) begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         req_type = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic signed [15:0] charge = '0;
    logic [15:0]        weight = '0;
    logic [1:0]         read_species = '0;
    logic [11:0]        read_cell = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    density_tracker tracker = new();
    int cycles = 0;
    int stall_mode = 0;
    int mode_left = 0;

    tsc_species_density_deposit_unit DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall) tracker.check_result(read_value, status);

    task automatic send(request_t r);
        req_valid <= 1'b1;
        req_type <= r.kind;
        pos_x <= r.px;
        pos_y <= r.py;
        pos_z <= r.pz;
        charge <= r.q;
        weight <= r.w;
        read_species <= r.sp;
        read_cell <= r.node_idx;
        do @(posedge clk); while (req_stall);
        tracker.note_request(r);
    endtask

    task automatic pause(int gap);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] vals[8]);
        wait_drained();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
            tracker.set_reg(i[2:0], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic request_t make_req(req_t k, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [15:0] q,
                                          logic [15:0] w);
        request_t r;
        r.kind = k;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.q = q;
        r.w = w;
        r.sp = 2'($urandom_range(0, 3));
        r.node_idx = 12'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] aim(logic [31:0] org, logic [31:0] inv);
        longint target;
        if (inv < 32'h1000 || inv > 32'h100000 || $urandom_range(0, 6) == 0) return $urandom;
        target = longint'($urandom_range(0, 15 * 65536)) - 65536;
        return org + 32'((target <<< 16) / longint'(inv));
    endfunction

    function automatic request_t random_req();
        request_t r;
        int pick;
        int off;
        pick = $urandom_range(0, 99);
        r = make_req(REQ_DEPOSIT,
                     aim(tracker.regs[REG_ORIGIN_X], tracker.regs[REG_INV_X]),
                     aim(tracker.regs[REG_ORIGIN_Y], tracker.regs[REG_INV_Y]),
                     aim(tracker.regs[REG_ORIGIN_Z], tracker.regs[REG_INV_Z]),
                     16'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) != 0) r.q = 16'($urandom_range(0, 1023) - 512);
        if ($urandom_range(0, 2) != 0) r.w = 16'($urandom_range(0, 1023));
        if (pick == 0) r.kind = REQ_CLEAR;
        else if (pick < 3) r.kind = REQ_NONE;
        else if (pick < 30) begin
            r.kind = REQ_READ;
            if ($urandom_range(0, 3) != 0) begin
                off = $urandom_range(0, 2) + NX * $urandom_range(0, 2)
                      + NX * NY * $urandom_range(0, 2);
                r.node_idx = 12'(tracker.last_idx + off);
                r.sp = 2'($urandom_range(0, 2));
            end
        end
        return r;
    endfunction

    initial
    begin
        logic [31:0] vals[8];
        request_t r;
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        vals = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0};
        configure(vals);
        send(make_req(REQ_DEPOSIT, 0, 0, 0, 16'h0100, 16'h0100));
        send(make_req(REQ_DEPOSIT, 32'h8000, 32'h8000, 32'h8000, 16'hff00, 16'h0100));
        send(make_req(REQ_DEPOSIT, 32'hc7d70, 32'h60000, 32'hc7d70, 16'h0000, 16'h0100));
        send(make_req(REQ_DEPOSIT, 32'hffff7fff, 0, 0, 16'h0100, 16'h0100));
        send(make_req(REQ_DEPOSIT, 0, 32'hc8000, 0, 16'h0100, 16'h0100));
        send(make_req(REQ_DEPOSIT, 32'h64000, 32'h64000, 32'h64000, 16'h8000, 16'hffff));
        for (int i = 0; i < 3; i++)
            send(make_req(REQ_DEPOSIT, 32'h20000, 32'h20000, 32'h20000, 16'h7fff, 16'hffff));
        send(make_req(REQ_DEPOSIT, 32'h30000, 32'h30000, 32'h30000, 16'h0100, 16'h0000));
        for (int s = 0; s < 4; s++)
        begin
            r = make_req(REQ_READ, 0, 0, 0, 0, 0);
            r.sp = 2'(s);
            r.node_idx = 12'd241;
            send(r);
        end
        r.sp = 1;
        r.node_idx = 12'd4095;
        send(r);
        r.node_idx = 12'(NODES - 1);
        send(r);
        r.node_idx = 12'(((3 * NY) + 3) * NX + 3);
        send(r);
        send(make_req(REQ_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff));
        send(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
        r.kind = REQ_READ;
        r.sp = 1;
        r.node_idx = 12'd241;
        send(r);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                vals = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h20000, 32'h20000,
                         32'h20000, 32'hffffffff, 0};
            else if (phase == 1)
                vals = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0,
                         32'hffffffff, 0, 7};
            else begin
                for (int i = 0; i < 3; i++)
                    vals[i] = ($urandom_range(0, 1) == 0) ? $urandom : 0;
                for (int i = 3; i < 6; i++)
                    vals[i] = ($urandom_range(0, 4) == 0) ? $urandom
                              : 32'h8000 << $urandom_range(0, 2);
                vals[REG_SCALE] = ($urandom_range(0, 2) == 0) ? $urandom
                                  : $urandom_range(32'h4000, 32'h20000);
                vals[REG_COLLAPSE] = $urandom_range(0, 7);
            end
            configure(vals);
            for (int n = 0; n < 70;)
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 70; b++, n++)
                    send(random_req());
                if (phase == 3 && n >= 35 && n < 35 + burst) wait_drained();
                else pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
            end
        end

        wait_drained();
        if (tracker.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

[filelist.f]
src/tscd_pkg.sv
src/tscd_ctrl.sv
src/tscd_datapath.sv
src/tsc_species_density_deposit_unit.sv
src/tscd_checker.sv
sim/tsc_species_density_deposit_unit_tb.sv
